// ----- rtl/core/clipped_sprite_blit_descriptor_macros.svh -----
// Assertion macros for the sprite blit descriptor block.
// Used by the top level; no other dependencies.
`ifndef CLIPPED_SPRITE_BLIT_DESCRIPTOR_MACROS_SVH
`define CLIPPED_SPRITE_BLIT_DESCRIPTOR_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CSBD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csbd assertion failed");
`define CSBD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error("csbd assertion failed");
`else
`define CSBD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CSBD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/core/csbd_pkg.sv -----
// Shared types and constants for the sprite blit descriptor block.
// No dependencies.
`timescale 1ns / 1ps

package csbd_pkg;

  localparam int MAX_SPRITES_DEF = 16;
  localparam int BUF_LOG2_DEF    = 22;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 8;
  localparam int OFS_W  = 22;

  localparam logic [2:0] REG_VIEW_LEFT   = 3'd0;
  localparam logic [2:0] REG_VIEW_TOP    = 3'd1;
  localparam logic [2:0] REG_VIEW_RIGHT  = 3'd2;
  localparam logic [2:0] REG_VIEW_BOTTOM = 3'd3;
  localparam logic [2:0] REG_ROW_BYTES   = 3'd4;
  localparam logic [2:0] REG_WIDE        = 3'd5;

  localparam logic [9:0]  VIEW_LEFT_RST   = 10'd0;
  localparam logic [9:0]  VIEW_TOP_RST    = 10'd0;
  localparam logic [9:0]  VIEW_RIGHT_RST  = 10'd319;
  localparam logic [9:0]  VIEW_BOTTOM_RST = 10'd239;
  localparam logic [11:0] ROW_BYTES_RST   = 12'd640;
  localparam logic        WIDE_RST        = 1'b1;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_PLACE  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    STAT_COPY     = 3'd0,
    STAT_UPDATED  = 3'd1,
    STAT_REJECT   = 3'd2,
    STAT_OFF_VIEW = 3'd3,
    STAT_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC
  } state_t;

  typedef struct packed {
    logic [9:0]  view_left;
    logic [9:0]  view_top;
    logic [9:0]  view_right;
    logic [9:0]  view_bottom;
    logic [11:0] screen_row_bytes;
    logic        wide_pixels;
  } cfg_t;

  typedef struct packed {
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic        bad_index;
  } place_cmd_t;

  typedef struct packed {
    status_t          status;
    logic [OFS_W-1:0] src_offset;
    logic [OFS_W-1:0] dst_address;
    logic [10:0]      row_bytes;
    logic [9:0]       row_count;
    logic [10:0]      src_stride;
  } res_t;

endpackage

// ----- rtl/core/csbd_ifs.sv -----
// Valid/ready channel interfaces for the command and result transfers.
// Depends on nothing but the payload widths of the block.
`timescale 1ns / 1ps

interface csbd_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  image_index;
  logic signed [11:0] pos_x;
  logic signed [11:0] pos_y;
  logic [9:0]  new_width;
  logic [9:0]  new_height;

  modport source(output valid, kind, image_index, pos_x, pos_y, new_width, new_height,
                 input ready);
  modport sink(input valid, kind, image_index, pos_x, pos_y, new_width, new_height,
               output ready);
endinterface

interface csbd_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [21:0] src_offset;
  logic [21:0] dst_address;
  logic [10:0] row_bytes;
  logic [9:0]  row_count;
  logic [10:0] src_stride;

  modport source(output valid, status, src_offset, dst_address, row_bytes, row_count,
                 src_stride, input ready);
  modport sink(input valid, status, src_offset, dst_address, row_bytes, row_count,
               src_stride, output ready);
endinterface

// ----- rtl/core/clipped_sprite_blit_descriptor.sv -----
// Sprite blit descriptor front end: table control, sequencer, result register.
// Depends on csbd_pkg, csbd_ifs, csbd_regs, csbd_table, csbd_place and the
// assertion macro header.
//
// Usage: commands arrive on the cmd channel (valid/ready), one result per
// command leaves on the res channel. Configuration must be written over APB
// only while the block is idle; the block itself does not enforce this. Clear,
// and an append that fits, update the table count and running buffer offset
// at the transfer edge; a clear or append result is registered and valid the
// next cycle, and a new command may follow every cycle while res.ready is
// high. For a place, the transfer edge issues the table read, the clip stage
// then registers the clipped window, and the result register then loads the
// place result. The cmd channel stays low-ready while a place is in flight,
// and while a result is held with res.ready low. Stalls on res only hold the
// result register; nothing is lost. Reset clears the count, the buffer offset,
// the sequencer and the result valid, and loads the register reset values;
// table contents are kept, and a place past the count is rejected.
`timescale 1ns / 1ps
`include "clipped_sprite_blit_descriptor_macros.svh"

module clipped_sprite_blit_descriptor #(
  parameter int MAX_SPRITES       = csbd_pkg::MAX_SPRITES_DEF,
  parameter int BUFFER_BYTES_LOG2 = csbd_pkg::BUF_LOG2_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  csbd_cmd_if.sink                     cmd,
  csbd_res_if.source                   res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [csbd_pkg::ADDR_W-1:0]  paddr,
  input  logic [csbd_pkg::DATA_W-1:0]  pwdata,
  output logic [csbd_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int IW   = (MAX_SPRITES > 1) ? $clog2(MAX_SPRITES) : 1;
  localparam int CW   = $clog2(MAX_SPRITES + 1);
  localparam int OW   = BUFFER_BYTES_LOG2 + 1;
  localparam int AW   = ((OW > 21) ? OW : 21) + 1;
  localparam int MW   = 20 + OW;
  localparam logic [AW-1:0] LIMIT = AW'(1) << BUFFER_BYTES_LOG2;

  csbd_pkg::cfg_t       cfg;
  csbd_pkg::state_t     state, state_next;
  csbd_pkg::place_cmd_t pcmd;
  csbd_pkg::res_t       imm_res, place_res, res_q;

  logic [CW-1:0]  entry_count;
  logic [OW-1:0]  next_offset;
  logic           res_valid, res_load, res_from_place, cmd_ready, acc;
  logic           is_place, is_append, is_clear, app_ok, place_load;
  logic [10:0]    app_line;
  logic [20:0]    app_bytes;
  logic [AW-1:0]  app_sum;
  logic [MW-1:0]  rd_data;

  csbd_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  assign acc       = cmd.valid && cmd_ready;
  assign is_clear  = csbd_pkg::kind_t'(cmd.kind) == csbd_pkg::KIND_CLEAR;
  assign is_append = csbd_pkg::kind_t'(cmd.kind) == csbd_pkg::KIND_APPEND;
  assign is_place  = csbd_pkg::kind_t'(cmd.kind) == csbd_pkg::KIND_PLACE;
  assign cmd.ready = cmd_ready;

  assign app_line  = cfg.wide_pixels ? {cmd.new_width, 1'b0} : {1'b0, cmd.new_width};
  assign app_bytes = 21'(app_line) * 21'(cmd.new_height);
  assign app_sum   = AW'(next_offset) + AW'(app_bytes);
  assign app_ok    = (entry_count < CW'(MAX_SPRITES)) && (app_sum <= LIMIT);

  csbd_table #(
    .DEPTH(MAX_SPRITES), .ADDR_W(IW), .DATA_W(MW)
  ) u_table (
    .clk,
    .we   (acc && is_append && app_ok),
    .waddr(entry_count[IW-1:0]),
    .wdata({cmd.new_width, cmd.new_height, next_offset}),
    .re   (acc && is_place),
    .raddr(cmd.image_index[IW-1:0]),
    .rdata(rd_data)
  );

  csbd_place u_place (
    .clk,
    .load      (place_load),
    .cfg,
    .pcmd,
    .ent_width (rd_data[MW-1 -: 10]),
    .ent_height(rd_data[MW-11 -: 10]),
    .ent_offset(csbd_pkg::OFS_W'(rd_data[OW-1:0])),
    .res       (place_res)
  );

  always_ff @(posedge clk) begin
    if (acc && is_place) begin
      pcmd.pos_x     <= cmd.pos_x;
      pcmd.pos_y     <= cmd.pos_y;
      pcmd.bad_index <= {1'b0, cmd.image_index} >= 9'(entry_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      next_offset <= '0;
    end else if (acc && is_clear) begin
      entry_count <= '0;
      next_offset <= '0;
    end else if (acc && is_append && app_ok) begin
      entry_count <= entry_count + CW'(1);
      next_offset <= app_sum[OW-1:0];
    end
  end

  always_comb begin
    imm_res = '0;
    if (is_clear || (is_append && app_ok)) begin
      imm_res.status = csbd_pkg::STAT_UPDATED;
    end else begin
      imm_res.status = csbd_pkg::STAT_REJECT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csbd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd_ready      = 1'b0;
    res_load       = 1'b0;
    res_from_place = 1'b0;
    place_load     = 1'b0;
    case (state)
      csbd_pkg::ST_IDLE: begin
        cmd_ready = !rst && (!res_valid || res.ready);
        if (cmd.valid && cmd_ready) begin
          if (is_place) begin
            state_next = csbd_pkg::ST_READ;
          end else begin
            res_load = 1'b1;
          end
        end
      end
      csbd_pkg::ST_READ: begin
        place_load = 1'b1;
        state_next = csbd_pkg::ST_CALC;
      end
      csbd_pkg::ST_CALC: begin
        res_load       = 1'b1;
        res_from_place = 1'b1;
        state_next     = csbd_pkg::ST_IDLE;
      end
      default: state_next = csbd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= res_from_place ? place_res : imm_res;
    end
  end

  assign res.valid       = res_valid;
  assign res.status      = res_q.status;
  assign res.src_offset  = res_q.src_offset;
  assign res.dst_address = res_q.dst_address;
  assign res.row_bytes   = res_q.row_bytes;
  assign res.row_count   = res_q.row_count;
  assign res.src_stride  = res_q.src_stride;

  `CSBD_ASSERT_IMP(a_count_max, clk, rst, 1'b1, entry_count <= CW'(MAX_SPRITES))
  `CSBD_ASSERT_IMP(a_offset_max, clk, rst, 1'b1, AW'(next_offset) <= LIMIT)
  `CSBD_ASSERT_NXT(a_place_latency, clk, rst, acc && is_place, ##2 res_valid)
  `CSBD_ASSERT_IMP(a_copy_nonempty, clk, rst, res_valid && res_q.status == csbd_pkg::STAT_COPY, res_q.row_count != '0 && res_q.row_bytes != '0)

endmodule

// ----- rtl/core/csbd_regs.sv -----
// APB configuration registers: viewport, screen row pitch, pixel size.
// Depends on csbd_pkg.
`timescale 1ns / 1ps

module csbd_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [csbd_pkg::ADDR_W-1:0]  paddr,
  input  logic [csbd_pkg::DATA_W-1:0]  pwdata,
  output logic [csbd_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output csbd_pkg::cfg_t               cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.view_left        <= csbd_pkg::VIEW_LEFT_RST;
      cfg.view_top         <= csbd_pkg::VIEW_TOP_RST;
      cfg.view_right       <= csbd_pkg::VIEW_RIGHT_RST;
      cfg.view_bottom      <= csbd_pkg::VIEW_BOTTOM_RST;
      cfg.screen_row_bytes <= csbd_pkg::ROW_BYTES_RST;
      cfg.wide_pixels      <= csbd_pkg::WIDE_RST;
    end else if (wr) begin
      case (idx)
        csbd_pkg::REG_VIEW_LEFT:   cfg.view_left        <= pwdata[9:0];
        csbd_pkg::REG_VIEW_TOP:    cfg.view_top         <= pwdata[9:0];
        csbd_pkg::REG_VIEW_RIGHT:  cfg.view_right       <= pwdata[9:0];
        csbd_pkg::REG_VIEW_BOTTOM: cfg.view_bottom      <= pwdata[9:0];
        csbd_pkg::REG_ROW_BYTES:   cfg.screen_row_bytes <= pwdata[11:0];
        csbd_pkg::REG_WIDE:        cfg.wide_pixels      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      csbd_pkg::REG_VIEW_LEFT:   prdata = 32'(cfg.view_left);
      csbd_pkg::REG_VIEW_TOP:    prdata = 32'(cfg.view_top);
      csbd_pkg::REG_VIEW_RIGHT:  prdata = 32'(cfg.view_right);
      csbd_pkg::REG_VIEW_BOTTOM: prdata = 32'(cfg.view_bottom);
      csbd_pkg::REG_ROW_BYTES:   prdata = 32'(cfg.screen_row_bytes);
      csbd_pkg::REG_WIDE:        prdata = 32'(cfg.wide_pixels);
      default:                   prdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/csbd_table.sv -----
// Sprite descriptor table: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module csbd_table #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int DATA_W = 43
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/csbd_place.sv -----
// Place datapath: clips a sprite against the viewport (registered stage),
// then forms source offset and destination address. Depends on csbd_pkg.
`timescale 1ns / 1ps

module csbd_place (
  input  logic                          clk,
  input  logic                          load,
  input  csbd_pkg::cfg_t                cfg,
  input  csbd_pkg::place_cmd_t          pcmd,
  input  logic [9:0]                    ent_width,
  input  logic [9:0]                    ent_height,
  input  logic [csbd_pkg::OFS_W-1:0]    ent_offset,
  output csbd_pkg::res_t                res
);

  logic signed [12:0] x, y, w, h, l, t, r, b;
  logic signed [12:0] xx, yy, sxl, sxr, syu, syd, cw, ch, xa, ya;
  csbd_pkg::status_t  st;

  csbd_pkg::status_t           st_q;
  logic [9:0]                  sxl_q, syu_q, cw_q, ch_q, xa_q, ya_q, w_q;
  logic [csbd_pkg::OFS_W-1:0]  off_q;

  logic [10:0]                 stride, col_s, col_d, rb;
  logic [20:0]                 prod_s;
  logic [21:0]                 prod_d;

  always_comb begin
    x  = {pcmd.pos_x[11], pcmd.pos_x};
    y  = {pcmd.pos_y[11], pcmd.pos_y};
    w  = {3'b000, ent_width};
    h  = {3'b000, ent_height};
    l  = {3'b000, cfg.view_left};
    t  = {3'b000, cfg.view_top};
    r  = {3'b000, cfg.view_right};
    b  = {3'b000, cfg.view_bottom};
    xx = x + w - 13'sd1;
    yy = y + h - 13'sd1;
    sxl = (x < l) ? l - x : '0;
    sxr = (xx > r) ? xx - r : '0;
    syu = (y < t) ? t - y : '0;
    syd = (yy > b) ? yy - b : '0;
    cw  = w - sxl - sxr;
    ch  = h - syu - syd;
    xa  = x + sxl;
    ya  = y + syu;
    if (pcmd.bad_index) begin
      st = csbd_pkg::STAT_REJECT;
    end else if (x < 0 || y < 0 || x > r || y > b || xx < l || yy < t) begin
      st = csbd_pkg::STAT_OFF_VIEW;
    end else if (cw <= 0 || ch <= 0) begin
      st = csbd_pkg::STAT_EMPTY;
    end else begin
      st = csbd_pkg::STAT_COPY;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      st_q  <= st;
      sxl_q <= sxl[9:0];
      syu_q <= syu[9:0];
      cw_q  <= cw[9:0];
      ch_q  <= ch[9:0];
      xa_q  <= xa[9:0];
      ya_q  <= ya[9:0];
      w_q   <= ent_width;
      off_q <= ent_offset;
    end
  end

  always_comb begin
    stride = cfg.wide_pixels ? {w_q, 1'b0} : {1'b0, w_q};
    col_s  = cfg.wide_pixels ? {sxl_q, 1'b0} : {1'b0, sxl_q};
    col_d  = cfg.wide_pixels ? {xa_q, 1'b0} : {1'b0, xa_q};
    rb     = cfg.wide_pixels ? {cw_q, 1'b0} : {1'b0, cw_q};
    prod_s = 21'(syu_q) * 21'(stride);
    prod_d = 22'(ya_q) * 22'(cfg.screen_row_bytes);
    res = '0;
    res.status = st_q;
    if (st_q == csbd_pkg::STAT_COPY) begin
      res.src_offset  = off_q + 22'(prod_s) + 22'(col_s);
      res.dst_address = prod_d + 22'(col_d);
      res.row_bytes   = rb;
      res.row_count   = ch_q;
      res.src_stride  = stride;
    end
  end

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the sprite blit descriptor block: table commands and
// clipped placements over valid/ready channels, viewport set over APB.
// Depends on csbd_pkg, csbd_ifs and the clipped_sprite_blit_descriptor top level.
`timescale 1ns / 1ps

module tb;
  import csbd_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int TABLE_DEPTH = MAX_SPRITES_DEF;
  localparam longint unsigned BUF_LIMIT = 64'd1 << BUF_LOG2_DEF;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 163;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  image_index;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [9:0]  new_width;
    logic [9:0]  new_height;
  } blit_cmd_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  csbd_cmd_if cmd_ch();
  csbd_res_if res_ch();

  clipped_sprite_blit_descriptor dut (
    .clk(clk), .rst(rst), .cmd(cmd_ch), .res(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // shadow of the block state
  cfg_t cfg_now = '{VIEW_LEFT_RST, VIEW_TOP_RST, VIEW_RIGHT_RST, VIEW_BOTTOM_RST,
                    ROW_BYTES_RST, WIDE_RST};
  logic [9:0] tbl_width [TABLE_DEPTH];
  logic [9:0] tbl_height [TABLE_DEPTH];
  longint unsigned tbl_offset [TABLE_DEPTH];
  int tbl_count = 0;
  longint unsigned buf_next = 0;

  blit_cmd_t cmd_backlog[$];
  res_t descriptors_due[$];
  blit_cmd_t nxt;
  blit_cmd_t seen;
  res_t want, got;
  int n_queued = 0;
  int n_accepted = 0;
  int n_errors = 0;
  int gen_entries = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit cmd_fired = 1'b0;
  bit hold_request = 1'b0;
  bit hold_started = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;

  function automatic res_t apply_command(blit_cmd_t c);
    res_t r;
    longint unsigned wv, hv, bytes, so, da;
    longint x, y, w, h, xe, ye, lv, tv, rv, bv, rowb;
    longint cl, cr, cu, cd, cw, ch, stride;
    int unsigned k;
    r = '0;
    r.status = STAT_REJECT;
    k = c.image_index;
    case (c.kind)
      KIND_CLEAR: begin
        tbl_count = 0;
        buf_next = 0;
        r.status = STAT_UPDATED;
      end
      KIND_APPEND: begin
        wv = c.new_width;
        hv = c.new_height;
        bytes = (wv << cfg_now.wide_pixels) * hv;
        if (tbl_count < TABLE_DEPTH && buf_next + bytes <= BUF_LIMIT) begin
          tbl_width[tbl_count] = c.new_width;
          tbl_height[tbl_count] = c.new_height;
          tbl_offset[tbl_count] = buf_next;
          tbl_count++;
          buf_next += bytes;
          r.status = STAT_UPDATED;
        end
      end
      KIND_PLACE: begin
        if (k < tbl_count) begin
          x = $signed(c.pos_x);
          y = $signed(c.pos_y);
          w = tbl_width[k];
          h = tbl_height[k];
          lv = cfg_now.view_left;
          tv = cfg_now.view_top;
          rv = cfg_now.view_right;
          bv = cfg_now.view_bottom;
          rowb = cfg_now.screen_row_bytes;
          xe = x + w - 1;
          ye = y + h - 1;
          if (x < 0 || y < 0 || x > rv || y > bv || xe < lv || ye < tv) begin
            r.status = STAT_OFF_VIEW;
          end else begin
            cl = (x < lv) ? lv - x : 0;
            cr = (xe > rv) ? xe - rv : 0;
            cu = (y < tv) ? tv - y : 0;
            cd = (ye > bv) ? ye - bv : 0;
            cw = w - cl - cr;
            ch = h - cu - cd;
            if (cw <= 0 || ch <= 0) begin
              r.status = STAT_EMPTY;
            end else begin
              stride = w << cfg_now.wide_pixels;
              so = tbl_offset[k] + cu * stride + (cl << cfg_now.wide_pixels);
              da = (y + cu) * rowb + ((x + cl) << cfg_now.wide_pixels);
              r.status = STAT_COPY;
              r.src_offset = OFS_W'(so);
              r.dst_address = OFS_W'(da);
              r.row_bytes = 11'(cw << cfg_now.wide_pixels);
              r.row_count = 10'(ch);
              r.src_stride = 11'(stride);
            end
          end
        end
      end
      default: r.status = STAT_REJECT;
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      n_errors++;
    end
  endfunction

  // command driver
  always @(negedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || cmd_fired) begin
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = cmd_backlog.pop_front();
        cmd_ch.valid <= 1'b1;
        cmd_ch.kind <= nxt.kind;
        cmd_ch.image_index <= nxt.image_index;
        cmd_ch.pos_x <= nxt.pos_x;
        cmd_ch.pos_y <= nxt.pos_y;
        cmd_ch.new_width <= nxt.new_width;
        cmd_ch.new_height <= nxt.new_height;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else if (hold_request && !hold_started) begin
      hold_started <= 1'b1;
      hold_left <= 400;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // monitor: check results first, then predict the accepted command
  always @(posedge clk) begin
    cmd_fired = !rst && cmd_ch.valid && cmd_ch.ready;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        got.status = status_t'(res_ch.status);
        got.src_offset = res_ch.src_offset;
        got.dst_address = res_ch.dst_address;
        got.row_bytes = res_ch.row_bytes;
        got.row_count = res_ch.row_count;
        got.src_stride = res_ch.src_stride;
        if (descriptors_due.size() == 0) begin
          $error("result transfer with no command outstanding");
          n_errors++;
        end else begin
          want = descriptors_due.pop_front();
          check_field("status", want.status, got.status);
          check_field("src_offset", want.src_offset, got.src_offset);
          check_field("dst_address", want.dst_address, got.dst_address);
          check_field("row_bytes", want.row_bytes, got.row_bytes);
          check_field("row_count", want.row_count, got.row_count);
          check_field("src_stride", want.src_stride, got.src_stride);
        end
      end
      if (cmd_fired) begin
        seen.kind = cmd_ch.kind;
        seen.image_index = cmd_ch.image_index;
        seen.pos_x = cmd_ch.pos_x;
        seen.pos_y = cmd_ch.pos_y;
        seen.new_width = cmd_ch.new_width;
        seen.new_height = cmd_ch.new_height;
        descriptors_due.push_back(apply_command(seen));
        n_accepted++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_cmd(logic [1:0] kind, logic [7:0] idx, logic [11:0] x,
                           logic [11:0] y, logic [9:0] w, logic [9:0] h);
    blit_cmd_t c;
    c = '{kind, idx, x, y, w, h};
    cmd_backlog.push_back(c);
    n_queued++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apply_view(cfg_t v);
    write_reg(REG_VIEW_LEFT, DATA_W'(v.view_left));
    write_reg(REG_VIEW_TOP, DATA_W'(v.view_top));
    write_reg(REG_VIEW_RIGHT, DATA_W'(v.view_right));
    write_reg(REG_VIEW_BOTTOM, DATA_W'(v.view_bottom));
    write_reg(REG_ROW_BYTES, DATA_W'(v.screen_row_bytes));
    write_reg(REG_WIDE, DATA_W'(v.wide_pixels));
    cfg_now = v;
  endtask

  task automatic drain();
    while (n_accepted != n_queued || descriptors_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [11:0] pick_coord(int lo_edge, int hi_edge);
    int a, b, v;
    if ($urandom_range(99) < 15) return 12'($urandom);
    a = lo_edge - 70;
    b = hi_edge + 8;
    if (b < a) begin
      v = a;
      a = b;
      b = v;
    end
    v = a + int'($urandom_range(b - a));
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return 12'(v);
  endfunction

  function automatic logic [9:0] pick_extent();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return 10'd0;
    if (roll < 20) return 10'($urandom);
    return 10'($urandom_range(64, 1));
  endfunction

  // a clear (in most sessions), a run of appends, then placements into the table
  task automatic queue_session();
    int n_app, n_plc, idx, roll;
    logic [9:0] w, h;
    if ($urandom_range(9) < 8) begin
      queue_cmd(KIND_CLEAR, 8'($urandom), 12'($urandom), 12'($urandom),
                10'($urandom), 10'($urandom));
      gen_entries = 0;
    end
    n_app = ($urandom_range(9) == 0) ? $urandom_range(18, 12) : $urandom_range(6, 1);
    for (int i = 0; i < n_app; i++) begin
      if ($urandom_range(15) == 0) begin
        w = 10'($urandom_range(1023, 900));
        h = 10'($urandom_range(1023, 900));
      end else begin
        w = pick_extent();
        h = pick_extent();
      end
      queue_cmd(KIND_APPEND, 8'($urandom), 12'($urandom), 12'($urandom), w, h);
      if (gen_entries < TABLE_DEPTH) gen_entries++;
    end
    n_plc = $urandom_range(14, 3);
    for (int i = 0; i < n_plc; i++) begin
      if ($urandom_range(19) == 0)
        queue_cmd(KIND_UNUSED, 8'($urandom), 12'($urandom), 12'($urandom),
                  10'($urandom), 10'($urandom));
      roll = $urandom_range(19);
      if (roll == 0) idx = $urandom_range(255);
      else if (roll == 1) idx = gen_entries;
      else idx = (gen_entries == 0) ? 0 : $urandom_range(gen_entries - 1);
      queue_cmd(KIND_PLACE, 8'(idx),
                pick_coord(cfg_now.view_left, cfg_now.view_right),
                pick_coord(cfg_now.view_top, cfg_now.view_bottom),
                10'($urandom), 10'($urandom));
    end
  endtask

  initial begin
    cfg_t v;
    int start, a, b;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.kind = '0;
    cmd_ch.image_index = '0;
    cmd_ch.pos_x = '0;
    cmd_ch.pos_y = '0;
    cmd_ch.new_width = '0;
    cmd_ch.new_height = '0;
    res_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 9; p++) begin
      if (p != 0) begin
        drain();
        case (p)
          1: v = '{10'd0, 10'd0, 10'd1023, 10'd1023, 12'd4095, 1'b0};
          2: v = '{10'd100, 10'd50, 10'd400, 10'd300, 12'd1000, 1'b1};
          3: v = '{10'd0, 10'd0, 10'd0, 10'd0, 12'd0, 1'b1};
          4: v = '{10'd500, 10'd400, 10'd200, 10'd100, 12'd2048, 1'b0};
          5: v = '{10'd1023, 10'd1023, 10'd1023, 10'd1023, 12'd1, 1'b1};
          default: begin
            a = $urandom_range(1023);
            b = $urandom_range(1023);
            v.view_left = 10'((a < b) ? a : b);
            v.view_right = 10'((a < b) ? b : a);
            a = $urandom_range(1023);
            b = $urandom_range(1023);
            v.view_top = 10'((a < b) ? a : b);
            v.view_bottom = 10'((a < b) ? b : a);
            v.screen_row_bytes = 12'($urandom);
            v.wide_pixels = 1'($urandom);
          end
        endcase
        apply_view(v);
      end
      tx_idle_pct = (p < 3) ? 36 : (p < 6) ? 68 : 0;
      rx_idle_pct = (p < 3) ? 68 : (p < 6) ? 36 : 0;
      if (p == 7) hold_request = 1'b1;
      if (p == 0) begin
        // empty table, unused kind, buffer overflow, zero-width sprite, edges
        queue_cmd(KIND_PLACE, 8'd0, 12'd0, 12'd0, 10'd0, 10'd0);
        queue_cmd(KIND_UNUSED, 8'hFF, 12'hFFF, 12'hFFF, 10'h3FF, 10'h3FF);
        queue_cmd(KIND_APPEND, 8'd0, 12'd0, 12'd0, 10'd1023, 10'd1023);
        queue_cmd(KIND_APPEND, 8'd0, 12'd0, 12'd0, 10'd1023, 10'd1023);
        queue_cmd(KIND_APPEND, 8'd0, 12'd0, 12'd0, 10'd1023, 10'd1023);
        queue_cmd(KIND_APPEND, 8'd0, 12'd0, 12'd0, 10'd0, 10'd0);
        queue_cmd(KIND_APPEND, 8'd0, 12'd0, 12'd0, 10'd16, 10'd8);
        queue_cmd(KIND_PLACE, 8'd2, 12'd10, 12'd10, 10'd0, 10'd0);
        queue_cmd(KIND_PLACE, 8'd3, 12'd0, 12'd0, 10'd0, 10'd0);
        queue_cmd(KIND_PLACE, 8'd3, 12'hFFF, 12'd5, 10'd0, 10'd0);
        queue_cmd(KIND_PLACE, 8'd3, 12'd5, 12'h800, 10'd0, 10'd0);
        queue_cmd(KIND_PLACE, 8'd3, 12'd319, 12'd239, 10'd0, 10'd0);
        queue_cmd(KIND_PLACE, 8'd3, 12'd320, 12'd0, 10'd0, 10'd0);
        queue_cmd(KIND_PLACE, 8'd3, 12'd0, 12'd240, 10'd0, 10'd0);
        queue_cmd(KIND_PLACE, 8'd0, 12'h7FF, 12'h7FF, 10'd0, 10'd0);
        queue_cmd(KIND_PLACE, 8'd0, 12'd100, 12'd100, 10'd0, 10'd0);
        queue_cmd(KIND_PLACE, 8'd4, 12'd0, 12'd0, 10'd0, 10'd0);
        queue_cmd(KIND_PLACE, 8'd255, 12'd0, 12'd0, 10'd0, 10'd0);
        queue_cmd(KIND_CLEAR, 8'hFF, 12'h800, 12'h800, 10'h3FF, 10'h3FF);
        // fill the buffer to exactly its end
        queue_cmd(KIND_APPEND, 8'd0, 12'd0, 12'd0, 10'd1023, 10'd1023);
        queue_cmd(KIND_APPEND, 8'd0, 12'd0, 12'd0, 10'd1023, 10'd1023);
        queue_cmd(KIND_APPEND, 8'd0, 12'd0, 12'd0, 10'd46, 10'd89);
        queue_cmd(KIND_APPEND, 8'd0, 12'd0, 12'd0, 10'd0, 10'd0);
        queue_cmd(KIND_PLACE, 8'd2, 12'd0, 12'd0, 10'd0, 10'd0);
        queue_cmd(KIND_APPEND, 8'd0, 12'd0, 12'd0, 10'd1, 10'd1);
        gen_entries = 4;
      end
      start = n_queued;
      while (n_queued - start < PHASE_ITEMS) queue_session();
    end

    drain();
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/csbd_pkg.sv
rtl/core/csbd_ifs.sv
rtl/core/csbd_regs.sv
rtl/core/csbd_table.sv
rtl/core/csbd_place.sv
rtl/core/clipped_sprite_blit_descriptor.sv
bench/tb.sv
